>>> rtl/bkf_pkg.sv
// bkf_pkg: shared types, widths and codes for the spin wait backoff controller
// no dependencies
`timescale 1ns / 1ps

package bkf_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int ACTION_W     = 3;
    localparam int IN_FRAC_W    = 16;
    localparam int SPIN_W       = 10;
    localparam int DELAY_W      = 20;
    localparam int COUNT_W      = 13;
    localparam int MAX_DELAYS_W = 12;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 20;

    localparam int FRAC_W = (FRACTION_BITS < IN_FRAC_W) ? FRACTION_BITS : IN_FRAC_W;
    localparam int PROD_W = DELAY_W + FRACTION_BITS + 1;

    localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FAILED = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ACQUIRED = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MERGE  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DELAYS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DELAY     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DELAY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPIN      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_UP       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SPIN  = 3'd6;

    localparam logic [MAX_DELAYS_W-1:0] RST_MAX_DELAYS = 12'd1000;
    localparam logic [DELAY_W-1:0]      RST_MIN_DELAY  = 20'd1000;
    localparam logic [DELAY_W-1:0]      RST_MAX_DELAY  = 20'd1000000;
    localparam logic [SPIN_W-1:0]       RST_MIN_SPIN   = 10'd10;
    localparam logic [SPIN_W-1:0]       RST_MAX_SPIN   = 10'd1000;
    localparam logic [SPIN_W-1:0]       RST_STEP_UP    = 10'd100;
    localparam logic [SPIN_W-1:0]       RST_INITIAL_SPIN = 10'd100;

    localparam logic [SPIN_W-1:0] SPIN_COUNT_MAX = {SPIN_W{1'b1}};

    typedef struct packed {
        logic [MAX_DELAYS_W-1:0] max_delays;
        logic [DELAY_W-1:0]      delay_floor;
        logic [DELAY_W-1:0]      delay_ceiling;
        logic [SPIN_W-1:0]       min_spin_limit;
        logic [SPIN_W-1:0]       max_spin_limit;
        logic [SPIN_W-1:0]       spin_limit_step_up;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [IN_FRAC_W-1:0] random_fraction;
        logic [SPIN_W-1:0]    shared_estimate;
    } request_t;

    typedef struct packed {
        logic               sleep_request;
        logic [DELAY_W-1:0] sleep_usec;
        logic               stuck;
        logic [COUNT_W-1:0] delays_so_far;
        logic [SPIN_W-1:0]  spin_limit_now;
        logic [SPIN_W-1:0]  merged_estimate;
    } result_t;

endpackage

>>> rtl/bkf_cfg_regs.sv
// bkf_cfg_regs: configuration register file, write only
// depends on bkf_pkg
`timescale 1ns / 1ps

module bkf_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bkf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bkf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bkf_pkg::cfg_t                  cfg
);
    import bkf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_delays         <= RST_MAX_DELAYS;
            cfg_reg.delay_floor        <= RST_MIN_DELAY;
            cfg_reg.delay_ceiling      <= RST_MAX_DELAY;
            cfg_reg.min_spin_limit     <= RST_MIN_SPIN;
            cfg_reg.max_spin_limit     <= RST_MAX_SPIN;
            cfg_reg.spin_limit_step_up <= RST_STEP_UP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_DELAYS:   cfg_reg.max_delays         <= cfg_data[MAX_DELAYS_W-1:0];
                REG_MIN_DELAY:    cfg_reg.delay_floor        <= cfg_data[DELAY_W-1:0];
                REG_MAX_DELAY:    cfg_reg.delay_ceiling      <= cfg_data[DELAY_W-1:0];
                REG_MIN_SPIN:     cfg_reg.min_spin_limit     <= cfg_data[SPIN_W-1:0];
                REG_MAX_SPIN:     cfg_reg.max_spin_limit     <= cfg_data[SPIN_W-1:0];
                REG_STEP_UP:      cfg_reg.spin_limit_step_up <= cfg_data[SPIN_W-1:0];
                // reset restores the initial limit, so a write never shows
                REG_INITIAL_SPIN: ;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bkf_engine.sv
// bkf_engine: wait state registers and the single pass next state and result logic
// depends on bkf_pkg
`timescale 1ns / 1ps

module bkf_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  bkf_pkg::request_t  req,
    input  bkf_pkg::cfg_t      cfg,
    output bkf_pkg::result_t   res
);
    import bkf_pkg::*;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

    logic [SPIN_W-1:0]  spin_count_reg,  spin_count_next;
    logic [COUNT_W-1:0] delay_count_reg, delay_count_next;
    logic [DELAY_W-1:0] cur_delay_reg,   cur_delay_next;
    logic [SPIN_W-1:0]  spin_limit_reg,  spin_limit_next;
    logic               stuck_reg,       stuck_next;

    logic [SPIN_W-1:0]  spin_inc;
    logic               hit;
    logic [DELAY_W-1:0] cur_eff;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  rounded;
    logic [DELAY_W:0]   grown;
    logic [SPIN_W:0]    limit_up;
    logic [SPIN_W+3:0]  merge_sum;
    logic [COUNT_W-1:0] max_delays_ext;

    always_comb
    begin
        spin_inc = (spin_count_reg < SPIN_COUNT_MAX) ? spin_count_reg + 1'b1 : spin_count_reg;
        hit      = (spin_inc >= spin_limit_reg);
        cur_eff  = (cur_delay_reg == '0) ? cfg.delay_floor : cur_delay_reg;
        prod     = PROD_W'(cur_eff) * PROD_W'(req.random_fraction[FRAC_W-1:0]);
        rounded  = prod + HALF;
        grown    = {1'b0, cur_eff} + rounded[PROD_W-1:FRACTION_BITS];
        limit_up = {1'b0, spin_limit_reg} + {1'b0, cfg.spin_limit_step_up};
        merge_sum = ({4'd0, req.shared_estimate} << 4) - {4'd0, req.shared_estimate}
                  + {4'd0, spin_limit_reg};
        max_delays_ext = {1'b0, cfg.max_delays};

        spin_count_next  = spin_count_reg;
        delay_count_next = delay_count_reg;
        cur_delay_next   = cur_delay_reg;
        spin_limit_next  = spin_limit_reg;
        stuck_next       = stuck_reg;

        res = '0;

        case (req.action)
            ACT_START:
            begin
                spin_count_next  = '0;
                delay_count_next = '0;
                cur_delay_next   = '0;
                stuck_next       = 1'b0;
            end
            ACT_FAILED:
            begin
                spin_count_next = spin_inc;
                if (hit)
                begin
                    spin_count_next = '0;
                    if (delay_count_reg <= max_delays_ext)
                    begin
                        delay_count_next = delay_count_reg + 1'b1;
                    end
                    if (delay_count_next > max_delays_ext)
                    begin
                        stuck_next = 1'b1;
                    end
                    res.sleep_request = 1'b1;
                    res.sleep_usec    = cur_eff;
                    if (grown > {1'b0, cfg.delay_ceiling})
                    begin
                        cur_delay_next = cfg.delay_floor;
                    end
                    else
                    begin
                        cur_delay_next = grown[DELAY_W-1:0];
                    end
                end
            end
            ACT_ACQUIRED:
            begin
                if (cur_delay_reg == '0)
                begin
                    if (spin_limit_reg < cfg.max_spin_limit)
                    begin
                        spin_limit_next = (limit_up < {1'b0, cfg.max_spin_limit})
                                        ? limit_up[SPIN_W-1:0] : cfg.max_spin_limit;
                    end
                end
                else if (spin_limit_reg > cfg.min_spin_limit)
                begin
                    spin_limit_next = spin_limit_reg - 1'b1;
                end
            end
            ACT_LOAD:
            begin
                spin_limit_next = req.shared_estimate;
            end
            ACT_MERGE:
            begin
                res.merged_estimate = merge_sum[SPIN_W+3:4];
            end
            default: ;
        endcase

        res.stuck          = stuck_next;
        res.delays_so_far  = delay_count_next;
        res.spin_limit_now = spin_limit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_count_reg  <= '0;
            delay_count_reg <= '0;
            cur_delay_reg   <= '0;
            spin_limit_reg  <= RST_INITIAL_SPIN;
            stuck_reg       <= 1'b0;
        end
        else if (advance)
        begin
            spin_count_reg  <= spin_count_next;
            delay_count_reg <= delay_count_next;
            cur_delay_reg   <= cur_delay_next;
            spin_limit_reg  <= spin_limit_next;
            stuck_reg       <= stuck_next;
        end
    end

endmodule

>>> rtl/spin_wait_backoff_controller_top.sv
// spin_wait_backoff_controller_top: request register, backoff engine, result register
// depends on bkf_pkg, bkf_cfg_regs, bkf_engine
`timescale 1ns / 1ps

// Backoff controller for a lock wait loop.
// Request channel: in_valid / in_stall with action, random_fraction and
// shared_estimate. A request is taken at a rising edge with in_valid high
// and in_stall low. Every request gives exactly one result.
// Result channel: out_valid / out_stall with sleep_request, sleep_usec,
// stuck, delays_so_far, spin_limit_now and merged_estimate; a result is
// taken at an edge with out_valid high and out_stall low.
// A request passes through the request register, then the engine's single
// pass of a 20 by 16 multiply, a round add and a wrap compare into the
// result register.
// Throughput is one request per cycle while out_stall stays low.
// When the receiver stalls, the result holds and one more request is
// buffered; in_stall then rises until the result is taken.
// Configuration: cfg_we, cfg_index, cfg_data, written while idle.
// Reset clears both valid flags and the wait state and restores register defaults.
module spin_wait_backoff_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bkf_pkg::ACTION_W-1:0]    action,
    input  logic [bkf_pkg::IN_FRAC_W-1:0]   random_fraction,
    input  logic [bkf_pkg::SPIN_W-1:0]      shared_estimate,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            sleep_request,
    output logic [bkf_pkg::DELAY_W-1:0]     sleep_usec,
    output logic                            stuck,
    output logic [bkf_pkg::COUNT_W-1:0]     delays_so_far,
    output logic [bkf_pkg::SPIN_W-1:0]      spin_limit_now,
    output logic [bkf_pkg::SPIN_W-1:0]      merged_estimate,
    input  logic                            cfg_we,
    input  logic [bkf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bkf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bkf_pkg::*;

    cfg_t     cfg;
    request_t req_reg;
    logic     req_valid_reg, req_valid_next;
    result_t  res;
    result_t  res_reg;
    logic     res_valid_reg, res_valid_next;
    logic     advance;
    logic     accept;

    assign advance  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && res_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = accept ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
        res_valid_next = advance ? 1'b1 : (out_stall ? res_valid_reg : 1'b0);
    end

    bkf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bkf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.action          <= action;
            req_reg.random_fraction <= random_fraction;
            req_reg.shared_estimate <= shared_estimate;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = res_valid_reg;
    assign sleep_request   = res_reg.sleep_request;
    assign sleep_usec      = res_reg.sleep_usec;
    assign stuck           = res_reg.stuck;
    assign delays_so_far   = res_reg.delays_so_far;
    assign spin_limit_now  = res_reg.spin_limit_now;
    assign merged_estimate = res_reg.merged_estimate;

endmodule

>>> rtl/bkf_checker.sv
// bkf_checker: port level assertions for the backoff controller, bound to the top level
// depends on bkf_pkg and spin_wait_backoff_controller_top
`timescale 1ns / 1ps

module bkf_port_props (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        sleep_request,
    input logic [bkf_pkg::DELAY_W-1:0] sleep_usec,
    input logic                        stuck,
    input logic [bkf_pkg::COUNT_W-1:0] delays_so_far
);
    import bkf_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // every taken request is followed by out_valid behind the request and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("no result two cycles after request");

    a_no_sleep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sleep_request |-> sleep_usec == '0)
        else $error("sleep length without sleep request");

    a_sleep_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sleep_request || stuck) |-> delays_so_far != '0)
        else $error("sleep or stuck with zero sleep count");

endmodule

bind spin_wait_backoff_controller_top bkf_port_props u_bkf_port_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sleep_request (sleep_request),
    .sleep_usec    (sleep_usec),
    .stuck         (stuck),
    .delays_so_far (delays_so_far)
);
